@@ src/sftg_pkg.sv @@
// Shared constants, types and the sine table builder for the faded sine tone generator.
// Used by every module of the block; depends on nothing else.
package sftg_pkg;

  localparam int INDEX_BITS = 24;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int MAG_BITS = SAMPLE_BITS - 1;

  localparam int PHASE_W = 32;
  localparam int TONE_W = 24;
  localparam int FADE_W = 16;
  localparam int GAIN_W = 25;
  localparam int ENV_W = 25;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 2;

  localparam int QUAD_SHIFT = PHASE_W - 2;
  localparam int ENV_SHIFT = 25;
  localparam int IDX_CMP_W = ((INDEX_BITS > TONE_W) ? INDEX_BITS : TONE_W) + 1;

  localparam logic [ENV_W-1:0] UNITY = ENV_W'(1) << 24;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd42852281;
  localparam logic [TONE_W-1:0] TONE_LENGTH_RESET = 24'd44100;
  localparam logic [FADE_W-1:0] FADE_LENGTH_RESET = 16'd220;
  localparam logic [GAIN_W-1:0] FADE_GAIN_RESET = 25'd76260;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP,
    REG_TONE_LENGTH,
    REG_FADE_LENGTH,
    REG_FADE_GAIN
  } sftg_reg_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic past_end;
  } sftg_tag_t;

  typedef logic [MAG_BITS-1:0] sftg_rom_t [SINE_TABLE_DEPTH];

  // Quarter-wave table sampled at cell midpoints, sine by a Q30 Taylor series.
  function automatic sftg_rom_t sftg_build_rom();
    sftg_rom_t   rom;
    logic [63:0] full_scale;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    full_scale = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x = ((64'(2 * k + 1)) * HALF_PI_Q30) / 64'(2 * SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * full_scale + (64'd1 << 29)) >> 30;
      if (v > full_scale) begin
        v = full_scale;
      end
      rom[k] = v[MAG_BITS-1:0];
    end
    return rom;
  endfunction

endpackage

@@ src/sftg_front.sv @@
// Front end: fade decision and phase product, then envelope product and table address.
// Depends on sftg_pkg.
module sftg_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sftg_pkg::INDEX_BITS-1:0]  sample_index,
  input  logic [sftg_pkg::PHASE_W-1:0]     phase_step,
  input  logic [sftg_pkg::TONE_W-1:0]      tone_length,
  input  logic [sftg_pkg::FADE_W-1:0]      fade_length,
  input  logic [sftg_pkg::GAIN_W-1:0]      fade_gain,
  output sftg_pkg::sftg_tag_t              tag,
  output logic [sftg_pkg::ADDR_BITS-1:0]   addr,
  output logic                             negate,
  output logic [sftg_pkg::ENV_W-1:0]       env
);
  import sftg_pkg::*;

  localparam int SCALE_W = QUAD_SHIFT + ADDR_BITS + 1;
  localparam int EPROD_W = TONE_W + GAIN_W;
  localparam logic [ADDR_BITS:0] DEPTH_W = (ADDR_BITS + 1)'(SINE_TABLE_DEPTH);
  localparam logic [ADDR_BITS-1:0] ADDR_LAST = ADDR_BITS'(SINE_TABLE_DEPTH - 1);

  logic [IDX_CMP_W-1:0] idx_w;
  logic [IDX_CMP_W-1:0] tone_w;
  logic [IDX_CMP_W-1:0] fade_w;
  logic                 in_fade;
  logic                 in_tail;
  logic [TONE_W-1:0]    count_next;
  logic [PHASE_W-1:0]   phase_next;

  sftg_tag_t            s1_tag;
  logic [PHASE_W-1:0]   s1_phase;
  logic [TONE_W-1:0]    s1_count;
  logic                 s1_unity;

  logic [EPROD_W-1:0]   env_prod;
  logic [ENV_W-1:0]     env_next;
  logic [SCALE_W-1:0]   addr_prod;
  logic [ADDR_BITS:0]   addr_raw;
  logic [ADDR_BITS-1:0] addr_clamp;
  logic [ADDR_BITS-1:0] addr_next;

  assign idx_w = IDX_CMP_W'(sample_index);
  assign tone_w = IDX_CMP_W'(tone_length);
  assign fade_w = IDX_CMP_W'(fade_length);
  assign in_fade = idx_w < fade_w;
  assign in_tail = (idx_w + fade_w) > tone_w;
  assign count_next = in_fade ? TONE_W'(idx_w) : TONE_W'(tone_w - idx_w);
  assign phase_next = PHASE_W'(sample_index) * phase_step;

  always_ff @(posedge clk) begin
    s1_tag.last <= (idx_w + IDX_CMP_W'(1)) == tone_w;
    s1_tag.past_end <= idx_w >= tone_w;
    s1_phase <= phase_next;
    s1_count <= count_next;
    s1_unity <= !in_fade && !in_tail;
    if (rst) begin
      s1_tag.valid <= 1'b0;
    end else begin
      s1_tag.valid <= start;
    end
  end

  assign env_prod = EPROD_W'(s1_count) * EPROD_W'(fade_gain);
  assign env_next = (s1_unity || (env_prod > EPROD_W'(UNITY))) ? UNITY : env_prod[ENV_W-1:0];

  assign addr_prod = SCALE_W'(s1_phase[QUAD_SHIFT-1:0]) * SCALE_W'(SINE_TABLE_DEPTH);
  assign addr_raw = addr_prod[SCALE_W-1:QUAD_SHIFT];
  assign addr_clamp = (addr_raw >= DEPTH_W) ? ADDR_LAST : addr_raw[ADDR_BITS-1:0];
  assign addr_next = s1_phase[QUAD_SHIFT] ? (ADDR_LAST - addr_clamp) : addr_clamp;

  always_ff @(posedge clk) begin
    tag.last <= s1_tag.last;
    tag.past_end <= s1_tag.past_end;
    addr <= addr_next;
    negate <= s1_phase[PHASE_W-1];
    env <= env_next;
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= s1_tag.valid;
    end
  end

endmodule

@@ src/sftg_rom.sv @@
// Quarter-wave sine table read with a registered output, plus the matching side-band delay.
// Depends on sftg_pkg for the table contents and widths.
module sftg_rom (
  input  logic                            clk,
  input  logic                            rst,
  input  sftg_pkg::sftg_tag_t             in_tag,
  input  logic [sftg_pkg::ADDR_BITS-1:0]  addr,
  input  logic                            in_negate,
  input  logic [sftg_pkg::ENV_W-1:0]      in_env,
  output sftg_pkg::sftg_tag_t             tag,
  output logic [sftg_pkg::MAG_BITS-1:0]   rom_data,
  output logic                            negate,
  output logic [sftg_pkg::ENV_W-1:0]      env
);
  import sftg_pkg::*;

  localparam sftg_rom_t SINE_ROM = sftg_build_rom();

  always_ff @(posedge clk) begin
    rom_data <= SINE_ROM[addr];
    tag.last <= in_tag.last;
    tag.past_end <= in_tag.past_end;
    negate <= in_negate;
    env <= in_env;
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= in_tag.valid;
    end
  end

endmodule

@@ src/sftg_scale.sv @@
// Back end: envelope scaling of the table value, then sign and output registers.
// Depends on sftg_pkg.
module sftg_scale (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sftg_pkg::sftg_tag_t                   in_tag,
  input  logic [sftg_pkg::MAG_BITS-1:0]         rom_data,
  input  logic                                  in_negate,
  input  logic [sftg_pkg::ENV_W-1:0]            in_env,
  output logic                                  done,
  output logic signed [sftg_pkg::MAG_BITS-1:0]  sample_value,
  output logic                                  last_sample,
  output logic                                  past_end
);
  import sftg_pkg::*;

  localparam int SPROD_W = MAG_BITS + ENV_W;

  logic [SPROD_W-1:0]  scale_prod;
  sftg_tag_t           s4_tag;
  logic [MAG_BITS-1:0] s4_mag;
  logic                s4_negate;

  assign scale_prod = SPROD_W'(rom_data) * SPROD_W'(in_env);

  always_ff @(posedge clk) begin
    s4_mag <= scale_prod[ENV_SHIFT +: MAG_BITS];
    s4_negate <= in_negate;
    s4_tag.last <= in_tag.last;
    s4_tag.past_end <= in_tag.past_end;
    if (rst) begin
      s4_tag.valid <= 1'b0;
    end else begin
      s4_tag.valid <= in_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_tag.past_end) begin
      sample_value <= '0;
    end else if (s4_negate) begin
      sample_value <= -s4_mag;
    end else begin
      sample_value <= s4_mag;
    end
    last_sample <= s4_tag.last;
    past_end <= s4_tag.past_end;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_tag.valid;
    end
  end

endmodule

@@ src/faded_sine_tone_generator_core.sv @@
// Top level of the faded sine tone generator: configuration registers and the pipeline.
// Depends on sftg_pkg, sftg_front, sftg_rom and sftg_scale.
//
// A beat is offered by raising start with sample_index; it is taken at any edge where
// start is high and busy is low. busy is always low, so a new index may be given in every
// cycle and the block sustains one sample per clock.
// Each index gives exactly one result beat: done is high for one cycle with sample_value,
// last_sample and past_end, once the beat has gone through the five register stages. The
// register stages are the phase and fade decision, the envelope and address products, the
// sine table read, the envelope scaling multiply and the sign/output register.
// Results come out in the order the indices went in. The receiver cannot stall; it must
// take each result in the cycle that done is high.
// Configuration is written through cfg_write, cfg_index and cfg_data at any edge and takes
// effect at once; it should only be changed while no beat is in flight.
// The synchronous reset empties the pipeline and loads the default tone settings: about
// 440 Hz, 44100 samples long, with 220-sample fades.
module faded_sine_tone_generator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [sftg_pkg::INDEX_BITS-1:0]       sample_index,
  output logic                                  done,
  output logic signed [sftg_pkg::MAG_BITS-1:0]  sample_value,
  output logic                                  last_sample,
  output logic                                  past_end,
  input  logic                                  cfg_write,
  input  logic [sftg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sftg_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import sftg_pkg::*;

  logic [PHASE_W-1:0]   phase_step;
  logic [TONE_W-1:0]    tone_length;
  logic [FADE_W-1:0]    fade_length;
  logic [GAIN_W-1:0]    fade_gain;

  sftg_tag_t            front_tag;
  logic [ADDR_BITS-1:0] front_addr;
  logic                 front_negate;
  logic [ENV_W-1:0]     front_env;

  sftg_tag_t            rom_tag;
  logic [MAG_BITS-1:0]  rom_data;
  logic                 rom_negate;
  logic [ENV_W-1:0]     rom_env;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= PHASE_STEP_RESET;
      tone_length <= TONE_LENGTH_RESET;
      fade_length <= FADE_LENGTH_RESET;
      fade_gain <= FADE_GAIN_RESET;
    end else if (cfg_write) begin
      unique case (sftg_reg_t'(cfg_index))
        REG_PHASE_STEP: phase_step <= cfg_data[PHASE_W-1:0];
        REG_TONE_LENGTH: tone_length <= cfg_data[TONE_W-1:0];
        REG_FADE_LENGTH: fade_length <= cfg_data[FADE_W-1:0];
        REG_FADE_GAIN: fade_gain <= cfg_data[GAIN_W-1:0];
        default: phase_step <= phase_step;
      endcase
    end
  end

  sftg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start && !busy),
    .sample_index (sample_index),
    .phase_step   (phase_step),
    .tone_length  (tone_length),
    .fade_length  (fade_length),
    .fade_gain    (fade_gain),
    .tag          (front_tag),
    .addr         (front_addr),
    .negate       (front_negate),
    .env          (front_env)
  );

  sftg_rom u_rom (
    .clk       (clk),
    .rst       (rst),
    .in_tag    (front_tag),
    .addr      (front_addr),
    .in_negate (front_negate),
    .in_env    (front_env),
    .tag       (rom_tag),
    .rom_data  (rom_data),
    .negate    (rom_negate),
    .env       (rom_env)
  );

  sftg_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .in_tag       (rom_tag),
    .rom_data     (rom_data),
    .in_negate    (rom_negate),
    .in_env       (rom_env),
    .done         (done),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .past_end     (past_end)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##5 done)
    else $error("accepted beat did not produce a result after five cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result strobe without a matching accepted beat");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(last_sample && past_end))
    else $error("last sample and past end flagged together");

  a_silent_end: assert property (@(posedge clk) disable iff (rst)
    done && past_end |-> sample_value == '0)
    else $error("non-zero sample beyond the end of the tone");

endmodule
